// ===== rtl/mhic_pkg.sv =====
// Shared constants for the magnetometer hard-iron calibration block:
// register indexes, reset values and default widths.
// No dependencies.
package mhic_pkg;

  // Default module parameters.
  localparam int AXIS_BITS_DEF      = 16;
  localparam int GAIN_FRAC_BITS_DEF = 14;

  // Fixed field widths.
  localparam int WORD_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int WINDOW_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AXES  = 3;

  // Axis slots.
  localparam int AXIS_ROLL  = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_YAW   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROLL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_YAW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_APPLY_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd4;

  // A 30 s window read every 100 ms.
  localparam int CAL_TIME_US    = 30000000;
  localparam int READ_PERIOD_US = 100000;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd16384;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(CAL_TIME_US / READ_PERIOD_US);

endpackage

// ===== rtl/magnetometer_hard_iron_calibration.sv =====
// Top level of the magnetometer hard-iron calibration block.
// Depends on mhic_pkg for register indexes, reset values and widths.
//
// The block takes one sample item per cycle while in_ready is high and returns
// one result item per sample, registered in the scaled stage and then in the
// output register. The first stage holds the gain-scaled, saturated axes (one
// 17x17 multiplier per axis); the second subtracts the offsets if apply_offset
// is set and updates min, max, the window counter and the offsets in a loop.
// A start flag seeds min and max with the sample; after window_samples samples
// the next sample sets each offset to the floor midpoint of min and max.
module magnetometer_hard_iron_calibration #(
  parameter int AXIS_BITS      = mhic_pkg::AXIS_BITS_DEF,
  parameter int GAIN_FRAC_BITS = mhic_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mhic_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhic_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mhic_pkg::WORD_W-1:0]  word0,
  input  logic signed [mhic_pkg::WORD_W-1:0]  word1,
  input  logic signed [mhic_pkg::WORD_W-1:0]  word2,
  input  logic                                start_cal,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mhic_pkg::WORD_W-1:0]  roll_out,
  output logic signed [mhic_pkg::WORD_W-1:0]  pitch_out,
  output logic signed [mhic_pkg::WORD_W-1:0]  yaw_out,
  output logic                                cal_running,
  output logic                                cal_done
);

  localparam int NA     = mhic_pkg::NUM_AXES;
  localparam int WW     = mhic_pkg::WORD_W;
  localparam int RAW_W  = WW + 1;
  localparam int PROD_W = RAW_W + mhic_pkg::GAIN_W + 1;
  localparam int SUM_W  = AXIS_BITS + 1;
  localparam int EXT_W  = 32;

  localparam logic signed [PROD_W-1:0] P_HI  = PROD_W'((64'sd1 <<< (AXIS_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] P_LO  = -P_HI - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'((64'sd1 <<< GAIN_FRAC_BITS) - 64'sd1);
  localparam logic signed [SUM_W-1:0]  D_HI  = SUM_W'((64'sd1 <<< (AXIS_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0]  D_LO  = -D_HI - SUM_W'(1);

  // Configuration registers.
  logic [mhic_pkg::GAIN_W-1:0]   gain [NA];
  logic                          apply_offset;
  logic [mhic_pkg::WINDOW_W-1:0] window_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NA; i++) gain[i] <= mhic_pkg::GAIN_RESET;
      apply_offset   <= 1'b0;
      window_samples <= mhic_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mhic_pkg::REG_GAIN_ROLL:    gain[mhic_pkg::AXIS_ROLL]  <= cfg_data;
        mhic_pkg::REG_GAIN_PITCH:   gain[mhic_pkg::AXIS_PITCH] <= cfg_data;
        mhic_pkg::REG_GAIN_YAW:     gain[mhic_pkg::AXIS_YAW]   <= cfg_data;
        mhic_pkg::REG_APPLY_OFFSET: apply_offset   <= cfg_data[0];
        mhic_pkg::REG_WINDOW:       window_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the scaled stage moves on whenever the output register is free.
  logic s1_valid;
  logic s2_load;
  logic s1_load;

  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;
  assign s1_load  = in_valid && in_ready;

  // Scaling: the product is truncated toward zero, then saturated.
  logic signed [RAW_W-1:0]     raw    [NA];
  logic signed [PROD_W-1:0]    prod   [NA];
  logic signed [PROD_W-1:0]    quot   [NA];
  logic signed [AXIS_BITS-1:0] scaled [NA];

  assign raw[mhic_pkg::AXIS_ROLL]  = RAW_W'(word0);
  assign raw[mhic_pkg::AXIS_PITCH] = RAW_W'(word2);
  assign raw[mhic_pkg::AXIS_YAW]   = -RAW_W'(word1);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      prod[i] = PROD_W'(raw[i]) * PROD_W'($signed({1'b0, gain[i]}));
      quot[i] = (prod[i] + (prod[i][PROD_W-1] ? ROUND : PROD_W'(0))) >>> GAIN_FRAC_BITS;
      if (quot[i] > P_HI) scaled[i] = P_HI[AXIS_BITS-1:0];
      else if (quot[i] < P_LO) scaled[i] = P_LO[AXIS_BITS-1:0];
      else scaled[i] = quot[i][AXIS_BITS-1:0];
    end
  end

  logic signed [AXIS_BITS-1:0] s1_a [NA];
  logic                        s1_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      for (int i = 0; i < NA; i++) s1_a[i] <= scaled[i];
      s1_start <= start_cal;
    end
  end

  // Calibration state.
  logic signed [AXIS_BITS-1:0]   axis_offset [NA];
  logic signed [AXIS_BITS-1:0]   axis_min    [NA];
  logic signed [AXIS_BITS-1:0]   axis_max    [NA];
  logic [mhic_pkg::WINDOW_W-1:0] window_count;
  logic                          tracking;
  logic                          finished;

  // A start sample sees cleared offsets and a fresh window.
  logic                          trk;
  logic [mhic_pkg::WINDOW_W-1:0] cnt;
  logic                          in_win;
  logic                          win_end;

  assign trk     = s1_start || tracking;
  assign cnt     = s1_start ? '0 : window_count;
  assign in_win  = trk && (cnt < window_samples);
  assign win_end = trk && !in_win;

  logic signed [AXIS_BITS-1:0] eff_off     [NA];
  logic signed [SUM_W-1:0]     diff        [NA];
  logic signed [AXIS_BITS-1:0] corr        [NA];
  logic signed [AXIS_BITS-1:0] base_min    [NA];
  logic signed [AXIS_BITS-1:0] base_max    [NA];
  logic signed [SUM_W-1:0]     mid_sum     [NA];
  logic signed [AXIS_BITS-1:0] min_next    [NA];
  logic signed [AXIS_BITS-1:0] max_next    [NA];
  logic signed [AXIS_BITS-1:0] offset_next [NA];
  logic signed [EXT_W-1:0]     corr_ext    [NA];

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      eff_off[i] = s1_start ? '0 : axis_offset[i];
      diff[i]    = SUM_W'(s1_a[i]) - SUM_W'(eff_off[i]);
      if (!apply_offset) corr[i] = s1_a[i];
      else if (diff[i] > D_HI) corr[i] = D_HI[AXIS_BITS-1:0];
      else if (diff[i] < D_LO) corr[i] = D_LO[AXIS_BITS-1:0];
      else corr[i] = diff[i][AXIS_BITS-1:0];

      base_min[i] = s1_start ? s1_a[i] : axis_min[i];
      base_max[i] = s1_start ? s1_a[i] : axis_max[i];
      min_next[i] = (in_win && (corr[i] < base_min[i])) ? corr[i] : base_min[i];
      max_next[i] = (in_win && (corr[i] > base_max[i])) ? corr[i] : base_max[i];

      // Floor of the midpoint: arithmetic shift of the widened sum.
      mid_sum[i]     = (SUM_W'(base_min[i]) + SUM_W'(base_max[i])) >>> 1;
      offset_next[i] = win_end ? mid_sum[i][AXIS_BITS-1:0] : eff_off[i];

      corr_ext[i] = EXT_W'(corr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NA; i++) begin
        axis_offset[i] <= '0;
        axis_min[i]    <= '0;
        axis_max[i]    <= '0;
      end
      window_count <= '0;
      tracking     <= 1'b0;
      finished     <= 1'b0;
    end else if (s2_load) begin
      for (int i = 0; i < NA; i++) begin
        axis_offset[i] <= offset_next[i];
        axis_min[i]    <= min_next[i];
        axis_max[i]    <= max_next[i];
      end
      window_count <= in_win ? cnt + 1'b1 : cnt;
      tracking     <= in_win;
      finished     <= win_end || (finished && !s1_start);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      roll_out    <= corr_ext[mhic_pkg::AXIS_ROLL][WW-1:0];
      pitch_out   <= corr_ext[mhic_pkg::AXIS_PITCH][WW-1:0];
      yaw_out     <= corr_ext[mhic_pkg::AXIS_YAW][WW-1:0];
      cal_running <= in_win;
      cal_done    <= win_end || (finished && !s1_start);
    end
  end

  // The window is never both open and closed with offsets computed.
  a_track_xor_done: assert property (@(posedge clk) disable iff (rst)
    !(tracking && finished))
    else $error("tracking and finished both set");

  // Closing the window always raises done.
  a_close_sets_done: assert property (@(posedge clk) disable iff (rst)
    $fell(tracking) |-> finished)
    else $error("window closed without offsets computed");

  // Offsets stay cleared for the whole tracking window.
  a_offsets_clear: assert property (@(posedge clk) disable iff (rst)
    tracking |-> (axis_offset[0] == '0 && axis_offset[1] == '0 && axis_offset[2] == '0))
    else $error("offset changed while tracking");

endmodule

// ===== tb/magnetometer_hard_iron_calibration_tb.sv =====
// Self-checking testbench for magnetometer_hard_iron_calibration: sample items go in over
// valid/ready, a local calibration tracker predicts every result item and the monitor checks it.
// Depends on mhic_pkg and the RTL of the block.
module magnetometer_hard_iron_calibration_tb;
  import mhic_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] w0;
    logic signed [WORD_W-1:0] w1;
    logic signed [WORD_W-1:0] w2;
    logic                     start;
  } sample_t;

  typedef struct {
    logic signed [WORD_W-1:0] roll;
    logic signed [WORD_W-1:0] pitch;
    logic signed [WORD_W-1:0] yaw;
    logic                     running;
    logic                     done;
  } axes_t;

  localparam longint AXIS_HI = (longint'(1) << (AXIS_BITS_DEF - 1)) - 1;
  localparam longint AXIS_LO = -AXIS_HI - 1;
  localparam logic [CFG_IDX_W-1:0] GAIN_REG [NUM_AXES] =
    '{REG_GAIN_ROLL, REG_GAIN_PITCH, REG_GAIN_YAW};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [WORD_W-1:0]   word0 = '0;
  logic signed [WORD_W-1:0]   word1 = '0;
  logic signed [WORD_W-1:0]   word2 = '0;
  logic                       start_cal = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [WORD_W-1:0]   roll_out;
  logic signed [WORD_W-1:0]   pitch_out;
  logic signed [WORD_W-1:0]   yaw_out;
  logic                       cal_running;
  logic                       cal_done;

  // Mirror of the block's registers and calibration state.
  logic [GAIN_W-1:0]   gain [NUM_AXES] = '{GAIN_RESET, GAIN_RESET, GAIN_RESET};
  logic                use_offset = 1'b0;
  logic [WINDOW_W-1:0] window_len = WINDOW_RESET;
  int                  offset [NUM_AXES] = '{0, 0, 0};
  int                  lo_seen [NUM_AXES] = '{0, 0, 0};
  int                  hi_seen [NUM_AXES] = '{0, 0, 0};
  int unsigned         window_cnt = 0;
  bit                  tracking = 1'b0;
  bit                  finished = 1'b0;

  sample_t pending_samples [$];
  axes_t   expected_axes [$];
  sample_t in_flight;
  axes_t   head;
  int      samples_queued = 0;
  int      samples_taken = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      idle_pct = 10;
  int      ph;

  magnetometer_hard_iron_calibration DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .word0(word0), .word1(word1), .word2(word2), .start_cal(start_cal),
    .out_valid(out_valid), .out_ready(out_ready),
    .roll_out(roll_out), .pitch_out(pitch_out), .yaw_out(yaw_out),
    .cal_running(cal_running), .cal_done(cal_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("magnetometer_hard_iron_calibration: mismatch");
    $finish;
  end

  function automatic int clamp_axis(input longint v);
    if (v > AXIS_HI) return int'(AXIS_HI);
    if (v < AXIS_LO) return int'(AXIS_LO);
    return int'(v);
  endfunction

  // The product is truncated toward zero, not floored.
  function automatic int scale_axis(input int raw, input logic [GAIN_W-1:0] g);
    longint p;
    p = longint'(raw) * longint'(g);
    if (p < 0) return clamp_axis(-((-p) >>> GAIN_FRAC_BITS_DEF));
    return clamp_axis(p >>> GAIN_FRAC_BITS_DEF);
  endfunction

  function automatic axes_t calibrate_sample(input sample_t s);
    int    a [NUM_AXES];
    axes_t r;
    int    i;
    a[AXIS_ROLL]  = scale_axis(int'(s.w0), gain[AXIS_ROLL]);
    a[AXIS_PITCH] = scale_axis(int'(s.w2), gain[AXIS_PITCH]);
    a[AXIS_YAW]   = scale_axis(-int'(s.w1), gain[AXIS_YAW]);
    if (s.start) begin
      for (i = 0; i < NUM_AXES; i++) begin
        offset[i] = 0;
        lo_seen[i] = a[i];
        hi_seen[i] = a[i];
      end
      window_cnt = 0;
      tracking = 1'b1;
      finished = 1'b0;
    end
    if (use_offset) begin
      for (i = 0; i < NUM_AXES; i++) a[i] = clamp_axis(longint'(a[i]) - longint'(offset[i]));
    end
    if (tracking) begin
      if (window_cnt < window_len) begin
        for (i = 0; i < NUM_AXES; i++) begin
          if (a[i] < lo_seen[i]) lo_seen[i] = a[i];
          if (a[i] > hi_seen[i]) hi_seen[i] = a[i];
        end
        window_cnt = (window_cnt + 1) & 32'hFFFF;
      end else begin
        // The closing sample is not tracked and still sees the cleared offsets.
        for (i = 0; i < NUM_AXES; i++) offset[i] = (lo_seen[i] + hi_seen[i]) >>> 1;
        tracking = 1'b0;
        finished = 1'b1;
      end
    end
    r.roll    = WORD_W'(a[AXIS_ROLL]);
    r.pitch   = WORD_W'(a[AXIS_PITCH]);
    r.yaw     = WORD_W'(a[AXIS_YAW]);
    r.running = tracking;
    r.done    = finished;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_axes.push_back(calibrate_sample(in_flight));
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_flight = pending_samples.pop_front();
          in_valid  <= 1'b1;
          word0     <= in_flight.w0;
          word1     <= in_flight.w1;
          word2     <= in_flight.w2;
          start_cal <= in_flight.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_axes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: roll %0d pitch %0d yaw %0d",
                     results_seen, roll_out, pitch_out, yaw_out);
        end else begin
          head = expected_axes.pop_front();
          if (roll_out !== head.roll || pitch_out !== head.pitch || yaw_out !== head.yaw ||
              cal_running !== head.running || cal_done !== head.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d expected/actual: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                        " running %0b/%0b done %0b/%0b"}, results_seen,
                       head.roll, roll_out, head.pitch, pitch_out, head.yaw, yaw_out,
                       head.running, cal_running, head.done, cal_done);
          end
        end
      end
    end
  end

  function automatic void queue_sample(input logic signed [WORD_W-1:0] w0,
                                       input logic signed [WORD_W-1:0] w1,
                                       input logic signed [WORD_W-1:0] w2,
                                       input logic start);
    sample_t s;
    s.w0 = w0;
    s.w1 = w1;
    s.w2 = w2;
    s.start = start;
    pending_samples.push_back(s);
    samples_queued++;
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_word();
    return WORD_W'($urandom);
  endfunction

  function automatic logic signed [WORD_W-1:0] near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return WORD_W'(v);
  endfunction

  // One complete calibration: a start item, the window, and a few items after it.
  function automatic int calibration_run();
    int c [NUM_AXES];
    int spread;
    int n;
    int k;
    bit wild;
    wild = ($urandom_range(3) == 0);
    spread = $urandom_range(1, 4000);
    for (k = 0; k < NUM_AXES; k++) c[k] = int'($urandom_range(24000)) - 12000;
    n = int'(window_len) + int'($urandom_range(1, 5));
    for (k = 0; k < n; k++) begin
      if (wild || $urandom_range(15) == 0)
        queue_sample(rand_word(), rand_word(), rand_word(), k == 0);
      else
        queue_sample(near(c[0], spread), near(c[1], spread), near(c[2], spread), k == 0);
    end
    return n;
  endfunction

  function automatic void random_phase(input int total);
    int made;
    int pick;
    int len;
    int k;
    made = 0;
    while (made < total) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        made += calibration_run();
      end else if (pick == 7) begin
        // Often cut short: the next item after this is usually a fresh start.
        len = $urandom_range(1, int'(window_len) + 1);
        for (k = 0; k < len; k++) queue_sample(rand_word(), rand_word(), rand_word(), k == 0);
        made += len;
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++)
          queue_sample(rand_word(), rand_word(), rand_word(), $urandom_range(40) == 0);
        made += len;
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_ROLL:    gain[AXIS_ROLL] = val;
      REG_GAIN_PITCH:   gain[AXIS_PITCH] = val;
      REG_GAIN_YAW:     gain[AXIS_YAW] = val;
      REG_APPLY_OFFSET: use_offset = val[0];
      REG_WINDOW:       window_len = val;
      default: ;
    endcase
  endtask

  task automatic random_setup();
    int k;
    for (k = 0; k < NUM_AXES; k++) begin
      case ($urandom_range(3))
        0: write_reg(GAIN_REG[k], GAIN_RESET);
        1: write_reg(GAIN_REG[k], 16'hFFFF);
        2: write_reg(GAIN_REG[k], CFG_W'($urandom_range(0, 20000)));
        default: write_reg(GAIN_REG[k], CFG_W'($urandom));
      endcase
    end
    write_reg(REG_APPLY_OFFSET, CFG_W'($urandom_range(1)));
    case ($urandom_range(5))
      0: write_reg(REG_WINDOW, 16'd0);
      1: write_reg(REG_WINDOW, 16'd1);
      default: write_reg(REG_WINDOW, CFG_W'($urandom_range(2, 40)));
    endcase
  endtask

  task automatic drain();
    do @(negedge clk); while (samples_taken != samples_queued || expected_axes.size() != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unity gains, no offsets, a 300 item window that stays open.
    queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
    queue_sample(16'sd32767, -16'sd32768, -16'sd32768, 1'b0);
    queue_sample(-16'sd32768, 16'sd32767, 16'sd32767, 1'b0);
    queue_sample(-16'sd1, 16'sd1, -16'sd1, 1'b0);
    queue_sample(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    queue_sample(16'sd100, 16'sd200, 16'sd300, 1'b1);
    drain();

    // Maximum gains saturate; a short window closes and the offsets are applied.
    write_reg(REG_GAIN_ROLL, 16'hFFFF);
    write_reg(REG_GAIN_PITCH, 16'hFFFF);
    write_reg(REG_GAIN_YAW, 16'hFFFF);
    write_reg(REG_APPLY_OFFSET, 16'd1);
    write_reg(REG_WINDOW, 16'd2);
    queue_sample(16'sd1000, -16'sd2000, 16'sd3000, 1'b1);
    queue_sample(-16'sd3000, 16'sd2500, -16'sd1000, 1'b0);
    queue_sample(16'sd500, 16'sd500, 16'sd500, 1'b0);
    queue_sample(16'sd32767, -16'sd32768, -16'sd32768, 1'b0);
    queue_sample(-16'sd32768, 16'sd32767, 16'sd32767, 1'b0);
    queue_sample(16'sd7, 16'sd7, 16'sd7, 1'b0);
    queue_sample(16'sd9000, 16'sd9000, -16'sd9000, 1'b1);
    queue_sample(-16'sd9000, -16'sd9000, 16'sd9000, 1'b0);
    drain();

    // Gains of 0, 1 and 16383 truncate negatives toward zero; a zero window closes on the start.
    write_reg(REG_GAIN_ROLL, 16'd0);
    write_reg(REG_GAIN_PITCH, 16'd1);
    write_reg(REG_GAIN_YAW, 16'd16383);
    write_reg(REG_WINDOW, 16'd0);
    queue_sample(16'sd1234, -16'sd1234, -16'sd4321, 1'b1);
    queue_sample(-16'sd5, 16'sd5, -16'sd5, 1'b0);
    queue_sample(-16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
    drain();
    write_reg(REG_APPLY_OFFSET, 16'd0);
    queue_sample(16'sd1, 16'sd2, 16'sd3, 1'b1);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      random_setup();
      idle_pct = (ph == 3) ? 0 : 10;
      if (ph == 5) begin
        random_phase(100);
        drain();
        random_phase(100);
      end else begin
        random_phase(200);
      end
      drain();
    end

    // Longest window: it never closes within these items.
    write_reg(REG_GAIN_ROLL, GAIN_RESET);
    write_reg(REG_GAIN_PITCH, GAIN_RESET);
    write_reg(REG_GAIN_YAW, GAIN_RESET);
    write_reg(REG_APPLY_OFFSET, 16'd1);
    write_reg(REG_WINDOW, 16'hFFFF);
    queue_sample(rand_word(), rand_word(), rand_word(), 1'b1);
    repeat (30) queue_sample(rand_word(), rand_word(), rand_word(), 1'b0);
    drain();
    write_reg(REG_WINDOW, 16'd1);
    random_phase(60);
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_axes.size() == 0) begin
      $display("magnetometer_hard_iron_calibration: match");
    end else begin
      $display("magnetometer_hard_iron_calibration: mismatch");
    end
    $finish;
  end

endmodule
